>>> rtl/ehd_pkg.sv
`default_nettype none
package ehd_pkg;

    localparam int BUFFER_BYTES = 4096;

    localparam logic [31:0] LOW_MASK  = 32'h0000_1fff;
    localparam logic [31:0] HIGH_MASK = 32'hffff_e000;
    localparam int          TRUNC_SHIFT = 13;

    localparam int VAL_W      = 34;
    localparam int DIGIT_W    = 7;
    localparam int LEB_DIGITS = (VAL_W + DIGIT_W - 1) / DIGIT_W;
    localparam int LEN_W      = $clog2(LEB_DIGITS + 1);
    localparam int NSEG       = 3;
    localparam int TOTAL_W    = $clog2(NSEG * LEB_DIGITS + 1);
    localparam int SUM_W      = 17;
    localparam logic [SUM_W-1:0] SIZE_LIMIT = SUM_W'(BUFFER_BYTES - 8);

    localparam logic [7:0] LEB_CONT = 8'h80;
    localparam logic [7:0] LEB_MASK = 8'h7f;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELTA,
        ST_FORMAT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [NSEG-1:0][VAL_W-1:0] val;
        logic [NSEG-1:0][LEN_W-1:0] len;
        logic [1:0]                 nseg;
    } t_seg_load;

    // Number of LEB128 bytes a value needs: highest non-zero digit plus one.
    function automatic logic [LEN_W-1:0] leb_len(input logic [VAL_W-1:0] v);
        logic [LEB_DIGITS*DIGIT_W-1:0] w;
        logic [LEN_W-1:0]              n;
        w = (LEB_DIGITS*DIGIT_W)'(v);
        n = LEN_W'(1);
        for (int d = 1; d < LEB_DIGITS; d++) begin
            if (w[DIGIT_W*d +: DIGIT_W] != '0) begin
                n = LEN_W'(d + 1);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ehd_fmt.sv
`default_nettype none
module ehd_fmt (
    input  wire logic [15:0]          i_code,
    input  wire logic [11:0]          i_size,
    input  wire logic [31:0]          i_delta,
    input  wire logic                 i_same,
    output ehd_pkg::t_seg_load        o_seg,
    output logic                      o_drop
);
    import ehd_pkg::*;

    logic                 coarse;
    logic [TOTAL_W-1:0]   total;
    logic [SUM_W-1:0]     sum;

    always_comb begin
        coarse = (i_delta & LOW_MASK) == '0;
        o_seg  = '0;
        if (i_same) begin
            if (coarse) begin
                o_seg.val[0] = VAL_W'(i_delta >> (TRUNC_SHIFT - 2)) | VAL_W'(2);
            end else begin
                o_seg.val[0] = {i_delta, 2'b00};
            end
            o_seg.nseg = 2'd1;
        end else begin
            o_seg.val[0] = VAL_W'({i_code, coarse, 1'b1});
            o_seg.val[1] = VAL_W'(i_size);
            o_seg.val[2] = coarse ? VAL_W'(i_delta >> TRUNC_SHIFT) : VAL_W'(i_delta);
            o_seg.nseg   = 2'd3;
        end
        for (int s = 0; s < NSEG; s++) begin
            o_seg.len[s] = leb_len(o_seg.val[s]);
        end
        total = TOTAL_W'(o_seg.len[0]);
        if (!i_same) begin
            total = total + TOTAL_W'(o_seg.len[1]) + TOTAL_W'(o_seg.len[2]);
        end
        sum    = SUM_W'(total) + SUM_W'(i_size);
        o_drop = sum > SIZE_LIMIT;
    end

endmodule
`default_nettype wire

>>> rtl/ehd_leb_ser.sv
`default_nettype none
module ehd_leb_ser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire ehd_pkg::t_seg_load   i_seg,
    input  wire logic                 i_advance,
    output logic [7:0]                o_byte,
    output logic                      o_last
);
    import ehd_pkg::*;

    logic [NSEG-1:0][VAL_W-1:0] r_val;
    logic [NSEG-1:0][LEN_W-1:0] r_len;
    logic [1:0]                 r_nseg;
    logic                       seg_end;

    assign seg_end = r_len[0] == LEN_W'(1);
    assign o_byte  = seg_end ? (8'(r_val[0][DIGIT_W-1:0]) & LEB_MASK)
                             : (8'(r_val[0][DIGIT_W-1:0]) | LEB_CONT);
    assign o_last  = seg_end && (r_nseg == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nseg <= '0;
        end else if (i_load) begin
            r_nseg <= i_seg.nseg;
        end else if (i_advance && seg_end && r_nseg != '0) begin
            r_nseg <= r_nseg - 2'd1;
        end
    end

    // One 7-bit digit leaves per accepted item; at a segment end the queue moves up.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= i_seg.val;
            r_len <= i_seg.len;
        end else if (i_advance) begin
            if (seg_end) begin
                for (int s = 0; s < NSEG - 1; s++) begin
                    r_val[s] <= r_val[s+1];
                    r_len[s] <= r_len[s+1];
                end
            end else begin
                r_val[0] <= r_val[0] >> DIGIT_W;
                r_len[0] <= r_len[0] - LEN_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/event_header_delta_leb128_encoder_core.sv
`default_nettype none
// Event header encoder: delta time stamps written as unsigned LEB128 bytes.
// Input channel (i_valid / o_ready) takes one event item: code, payload size,
// time stamp, low-resolution flag and history-restart flag. Output channel
// (o_valid / i_ready) returns the header as 1 to 10 byte items, with
// o_last_byte set on the final byte of each header.
// An accepted event first passes a state that forms the time delta, then a state
// that chooses the header format and byte counts and loads the 7-bit digit shift
// register; its first byte is then shown, and one byte leaves per cycle while
// i_ready is high, the shift register sending the bytes one at a time.
// o_ready is high only while no event is in progress.
// An event whose header plus payload would not fit the buffer gives no byte
// and leaves history untouched, apart from a requested restart.
// When the receiver stalls, the current byte is held and the shifter waits.
// Reset (synchronous, active low) clears the previous code, size and time
// and leaves the block ready for a new event.
module event_header_delta_leb128_encoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_event_code,
    input  wire logic [11:0] i_payload_size,
    input  wire logic [31:0] i_time_now,
    input  wire logic        i_low_res,
    input  wire logic        i_restart_history,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_header_byte,
    output logic             o_last_byte
);
    import ehd_pkg::*;

    t_state      r_state, n_state;
    logic [15:0] r_code;
    logic [11:0] r_size;
    logic [31:0] r_time;
    logic        r_low_res;
    logic [15:0] r_prev_code;
    logic [11:0] r_prev_size;
    logic [31:0] r_prev_time;
    logic [31:0] r_tq;
    logic [31:0] r_delta;
    logic [31:0] n_tq;

    t_seg_load   seg;
    logic        drop;
    logic        same;
    logic        in_acc;
    logic        out_acc;
    logic        ser_load;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign same    = (r_code == r_prev_code) && (r_size == r_prev_size);

    // Truncate only where the time cannot step backwards.
    always_comb begin
        n_tq = r_time;
        if (r_low_res && (((r_prev_time & LOW_MASK) == '0) ||
                          ((r_prev_time & HIGH_MASK) != (r_time & HIGH_MASK)))) begin
            n_tq = r_time & HIGH_MASK;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_DELTA;
            ST_DELTA:  n_state = ST_FORMAT;
            ST_FORMAT: n_state = drop ? ST_IDLE : ST_EMIT;
            ST_EMIT:   if (out_acc && o_last_byte) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        o_valid  = 1'b0;
        ser_load = 1'b0;
        case (r_state)
            ST_IDLE:   o_ready  = 1'b1;
            ST_DELTA:  ;
            ST_FORMAT: ser_load = !drop;
            ST_EMIT:   o_valid  = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // History: a restart is applied at acceptance, so it stands even if dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_code <= '0;
            r_prev_size <= '0;
            r_prev_time <= '0;
        end else if (in_acc && i_restart_history) begin
            r_prev_code <= '0;
            r_prev_size <= '0;
            r_prev_time <= '0;
        end else if (ser_load) begin
            r_prev_code <= r_code;
            r_prev_size <= r_size;
            r_prev_time <= r_tq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code    <= i_event_code;
            r_size    <= i_payload_size;
            r_time    <= i_time_now;
            r_low_res <= i_low_res;
        end
        if (r_state == ST_DELTA) begin
            r_tq    <= n_tq;
            r_delta <= n_tq - r_prev_time;
        end
    end

    ehd_fmt u_fmt (
        .i_code  (r_code),
        .i_size  (r_size),
        .i_delta (r_delta),
        .i_same  (same),
        .o_seg   (seg),
        .o_drop  (drop)
    );

    ehd_leb_ser u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (ser_load),
        .i_seg     (seg),
        .i_advance (out_acc),
        .o_byte    (o_header_byte),
        .o_last    (o_last_byte)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input taken while a header is being sent");

    a_no_byte_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_valid)
        else $error("header byte shown before the delta was formed");

    a_last_has_no_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_byte) |-> !o_header_byte[7])
        else $error("final header byte carries a continuation bit");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_byte) |=> o_ready)
        else $error("block not ready after the final header byte");
`endif

endmodule
`default_nettype wire
